[hdl/plc_pkg.sv]
// shared constants, register codes and the tag word for the curve evaluator
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package plc_pkg;

    localparam int MAX_POINTS_DEF  = 7;
    localparam int COORD_BITS_DEF  = 16;
    localparam int MIN_POINTS      = 2;

    localparam int SAMPLE_W   = 17;
    localparam int VALUE_W    = 32;
    localparam int SEG_W      = 3;
    localparam int PCOUNT_W   = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int PX_LSB     = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE  = 4'd1;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 3'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // control word carried alongside the arithmetic
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             bypass;  // result is the start y as it stands
        logic             zerr;
        logic             qneg;    // quotient sign
    } t_tag;

endpackage

[hdl/plc_regs.sv]
// configuration registers: point count and control points, with count clamping
// depends on plc_pkg
`timescale 1ns / 1ps

module plc_regs #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [COORD_BITS-1:0]           o_px [MAX_POINTS],
    output logic signed [COORD_BITS-1:0]    o_py [MAX_POINTS],
    output logic [plc_pkg::PCOUNT_W-1:0]    o_n_use
);
    import plc_pkg::*;

    logic [PCOUNT_W-1:0]          r_count;
    logic [COORD_BITS-1:0]        r_px [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_py [MAX_POINTS];
    logic                         w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;

    // point 1 resets to (1, 1), all others to the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= PCOUNT_RESET;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_px[k] <= COORD_BITS'(k == 1);
                r_py[k] <= COORD_BITS'(k == 1);
            end
        end else if (w_wr) begin
            if (i_cfg_index == REG_POINT_COUNT) begin
                r_count <= i_cfg_data[PCOUNT_W-1:0];
            end
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (i_cfg_index == CFG_IDX_W'(int'(REG_POINT_BASE) + k)) begin
                    r_px[k] <= i_cfg_data[PX_LSB +: COORD_BITS];
                    r_py[k] <= i_cfg_data[COORD_BITS-1:0];
                end
            end
        end
    end

    always_comb begin
        if (r_count < PCOUNT_W'(MIN_POINTS)) begin
            o_n_use = PCOUNT_W'(MIN_POINTS);
        end else if (r_count > PCOUNT_W'(MAX_POINTS)) begin
            o_n_use = PCOUNT_W'(MAX_POINTS);
        end else begin
            o_n_use = r_count;
        end
    end

    assign o_px = r_px;
    assign o_py = r_py;

endmodule

[hdl/plc_front.sv]
// front stages: segment search, operand fetch, multiply, sign split for the divider
// depends on plc_pkg; fed by plc_regs, feeds plc_div
`timescale 1ns / 1ps

module plc_front #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF,
    localparam int DVD_W     = plc_pkg::SAMPLE_W - 1 + COORD_BITS,
    localparam int STAGES    = (DVD_W + 1) / 2,
    localparam int DVD_PW    = 2 * STAGES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [plc_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [COORD_BITS-1:0]               i_px [MAX_POINTS],
    input  logic signed [COORD_BITS-1:0]        i_py [MAX_POINTS],
    input  logic [plc_pkg::PCOUNT_W-1:0]        i_n_use,
    output logic                                o_valid,
    output plc_pkg::t_tag                       o_tag,
    output logic signed [COORD_BITS-1:0]        o_y0,
    output logic [DVD_PW-1:0]                   o_dvd,
    output logic [COORD_BITS-1:0]               o_dvs
);
    import plc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int PI_W   = $clog2(MAX_POINTS);
    localparam int PROD_W = CB + 1 + SAMPLE_W;

    // stage 1: segment search
    logic                        r1_valid;
    logic signed [SAMPLE_W-1:0]  r1_sample;
    logic [SEG_W-1:0]            r1_seg;
    logic                        r1_neg;
    logic [SEG_W-1:0]            n1_seg;

    always_comb begin
        logic stop;
        stop   = 1'b0;
        n1_seg = '0;
        // last segment whose start is at or below the sample, stopping at the first miss
        for (int k = 1; k < MAX_POINTS - 1; k++) begin
            if (!stop && (k + 1 < int'(i_n_use))
                    && ($unsigned(i_sample_in) >= SAMPLE_W'(i_px[k]))) begin
                n1_seg = SEG_W'(k);
            end else begin
                stop = 1'b1;
            end
        end
        if (i_sample_in[SAMPLE_W-1]) begin
            n1_seg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sample <= i_sample_in;
        r1_seg    <= n1_seg;
        r1_neg    <= i_sample_in[SAMPLE_W-1];
    end

    // stage 2: fetch segment ends, form differences
    logic [PI_W-1:0]             w_sel;
    logic [PI_W-1:0]             w_sel_nx;
    logic [CB-1:0]               w_x0;
    logic [CB-1:0]               w_x1;
    logic signed [CB-1:0]        w_y0;
    logic signed [CB-1:0]        w_y1;
    logic signed [CB:0]          n2_dx;
    logic signed [CB:0]          n2_dy;
    logic signed [SAMPLE_W-1:0]  n2_ds;
    t_tag                        n2_tag;

    logic                        r2_valid;
    t_tag                        r2_tag;
    logic signed [CB-1:0]        r2_y0;
    logic signed [CB:0]          r2_dx;
    logic signed [CB:0]          r2_dy;
    logic signed [SAMPLE_W-1:0]  r2_ds;

    assign w_sel    = r1_seg[PI_W-1:0];
    assign w_sel_nx = w_sel + PI_W'(1);
    assign w_x0     = i_px[w_sel];
    assign w_x1     = i_px[w_sel_nx];
    assign w_y0     = i_py[w_sel];
    assign w_y1     = i_py[w_sel_nx];

    always_comb begin
        n2_dx = $signed({1'b0, w_x1}) - $signed({1'b0, w_x0});
        n2_dy = $signed({w_y1[CB-1], w_y1}) - $signed({w_y0[CB-1], w_y0});
        n2_ds = r1_sample - $signed(SAMPLE_W'(w_x0));
        n2_tag.seg    = r1_seg;
        n2_tag.zerr   = !r1_neg && (n2_dx == '0);
        n2_tag.bypass = r1_neg || (n2_dx == '0);
        n2_tag.qneg   = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_tag <= n2_tag;
        r2_y0  <= w_y0;
        r2_dx  <= n2_dx;
        r2_dy  <= n2_dy;
        r2_ds  <= n2_ds;
    end

    // stage 3: product of rise and offset
    logic                        r3_valid;
    t_tag                        r3_tag;
    logic signed [CB-1:0]        r3_y0;
    logic signed [CB:0]          r3_dx;
    logic signed [PROD_W-1:0]    r3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_tag  <= r2_tag;
        r3_y0   <= r2_y0;
        r3_dx   <= r2_dx;
        r3_prod <= r2_dy * r2_ds;
    end

    // stage 4: magnitudes and quotient sign, so the divider works unsigned
    logic signed [PROD_W-1:0]    n4_pabs;
    logic signed [CB:0]          n4_dabs;
    t_tag                        n4_tag;

    logic                        r4_valid;
    t_tag                        r4_tag;
    logic signed [CB-1:0]        r4_y0;
    logic [DVD_PW-1:0]           r4_dvd;
    logic [CB-1:0]               r4_dvs;

    always_comb begin
        n4_pabs     = r3_prod[PROD_W-1] ? -r3_prod : r3_prod;
        n4_dabs     = r3_dx[CB] ? -r3_dx : r3_dx;
        n4_tag      = r3_tag;
        n4_tag.qneg = r3_prod[PROD_W-1] ^ r3_dx[CB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_tag <= n4_tag;
        r4_y0  <= r3_y0;
        r4_dvd <= n4_pabs[DVD_PW-1:0];
        r4_dvs <= n4_dabs[CB-1:0];
    end

    assign o_valid = r4_valid;
    assign o_tag   = r4_tag;
    assign o_y0    = r4_y0;
    assign o_dvd   = r4_dvd;
    assign o_dvs   = r4_dvs;

endmodule

[hdl/plc_div.sv]
// pipelined restoring divider, two quotient bits per stage, side data carried along
// depends on plc_pkg; fed by plc_front
`timescale 1ns / 1ps

module plc_div #(
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF,
    localparam int DVD_W     = plc_pkg::SAMPLE_W - 1 + COORD_BITS,
    localparam int STAGES    = (DVD_W + 1) / 2,
    localparam int DVD_PW    = 2 * STAGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  plc_pkg::t_tag                 i_tag,
    input  logic signed [COORD_BITS-1:0]  i_y0,
    input  logic [DVD_PW-1:0]             i_dvd,
    input  logic [COORD_BITS-1:0]         i_dvs,
    output logic                          o_valid,
    output plc_pkg::t_tag                 o_tag,
    output logic signed [COORD_BITS-1:0]  o_y0,
    output logic [DVD_PW-1:0]             o_quo
);
    import plc_pkg::*;

    localparam int CB = COORD_BITS;

    // two shift-subtract steps; quotient bits enter as dividend bits leave
    function automatic logic [CB+DVD_PW-1:0] div_step2(
        input logic [CB-1:0]     rem,
        input logic [DVD_PW-1:0] quo,
        input logic [CB-1:0]     dvs
    );
        logic [CB:0]       sh;
        logic [CB-1:0]     rm;
        logic [DVD_PW-1:0] q;
        rm = rem;
        q  = quo;
        for (int i = 0; i < 2; i++) begin
            sh = {rm, q[DVD_PW-1]};
            q  = {q[DVD_PW-2:0], 1'b0};
            if (sh >= {1'b0, dvs}) begin
                sh   = sh - {1'b0, dvs};
                q[0] = 1'b1;
            end
            rm = sh[CB-1:0];
        end
        return {rm, q};
    endfunction

    logic                 a_valid [STAGES];
    t_tag                 a_tag   [STAGES];
    logic signed [CB-1:0] a_y0    [STAGES];
    logic [CB-1:0]        a_rem   [STAGES];
    logic [DVD_PW-1:0]    a_quo   [STAGES];
    logic [CB-1:0]        a_dvs   [STAGES];

    logic                 r_valid [STAGES];
    t_tag                 r_tag   [STAGES];
    logic signed [CB-1:0] r_y0    [STAGES];
    logic [CB-1:0]        r_rem   [STAGES];
    logic [DVD_PW-1:0]    r_quo   [STAGES];
    logic [CB-1:0]        r_dvs   [STAGES];

    logic [CB+DVD_PW-1:0] n_step  [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign a_valid[g] = i_valid;
            assign a_tag[g]   = i_tag;
            assign a_y0[g]    = i_y0;
            assign a_rem[g]   = '0;
            assign a_quo[g]   = i_dvd;
            assign a_dvs[g]   = i_dvs;
        end else begin : g_next
            assign a_valid[g] = r_valid[g-1];
            assign a_tag[g]   = r_tag[g-1];
            assign a_y0[g]    = r_y0[g-1];
            assign a_rem[g]   = r_rem[g-1];
            assign a_quo[g]   = r_quo[g-1];
            assign a_dvs[g]   = r_dvs[g-1];
        end

        assign n_step[g] = div_step2(a_rem[g], a_quo[g], a_dvs[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= a_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[g] <= a_tag[g];
            r_y0[g]  <= a_y0[g];
            r_dvs[g] <= a_dvs[g];
            r_rem[g] <= n_step[g][CB+DVD_PW-1:DVD_PW];
            r_quo[g] <= n_step[g][DVD_PW-1:0];
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];
    assign o_y0    = r_y0[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];

endmodule

[hdl/piecewise_linear_interpolator_core.sv]
// piecewise-linear curve evaluator, top level: registers, front stages, divider, output stages
// depends on plc_pkg, plc_regs, plc_front, plc_div
//
//   channel   handshake                   word
//   sample    start / busy                i_sample_in
//   result    o_done strobe               o_curve_value, o_segment_index,
//                                         o_zero_width_error, o_overflow_flag
//   config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one sample per cycle while busy is low; the result strobe follows the start word through the
// front stages, the divider stages and the output stages
// i_rst_n is synchronous: it empties the pipeline and loads the register reset values
// busy is high only during reset and the cycle after it; config ready is always high
// the result port has no back-pressure: each strobe lasts one cycle
`timescale 1ns / 1ps

module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [plc_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_done,
    output logic signed [plc_pkg::VALUE_W-1:0]  o_curve_value,
    output logic [plc_pkg::SEG_W-1:0]           o_segment_index,
    output logic                                o_zero_width_error,
    output logic                                o_overflow_flag,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import plc_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int DVD_W   = SAMPLE_W - 1 + COORD_BITS;
    localparam int STAGES  = (DVD_W + 1) / 2;
    localparam int DVD_PW  = 2 * STAGES;
    localparam int SUM_W   = (DVD_PW + 2 > VALUE_W + 1) ? DVD_PW + 2 : VALUE_W + 1;
    localparam int LAT     = STAGES + 7;

    logic [CB-1:0]          w_px [MAX_POINTS];
    logic signed [CB-1:0]   w_py [MAX_POINTS];
    logic [PCOUNT_W-1:0]    w_n_use;
    logic                   w_accept;

    logic                   f_valid;
    t_tag                   f_tag;
    logic signed [CB-1:0]   f_y0;
    logic [DVD_PW-1:0]      f_dvd;
    logic [CB-1:0]          f_dvs;

    logic                   d_valid;
    t_tag                   d_tag;
    logic signed [CB-1:0]   d_y0;
    logic [DVD_PW-1:0]      d_quo;

    logic                   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !busy;

    plc_regs #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_px        (w_px),
        .o_py        (w_py),
        .o_n_use     (w_n_use)
    );

    plc_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_sample_in (i_sample_in),
        .i_px        (w_px),
        .i_py        (w_py),
        .i_n_use     (w_n_use),
        .o_valid     (f_valid),
        .o_tag       (f_tag),
        .o_y0        (f_y0),
        .o_dvd       (f_dvd),
        .o_dvs       (f_dvs)
    );

    plc_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_tag   (f_tag),
        .i_y0    (f_y0),
        .i_dvd   (f_dvd),
        .i_dvs   (f_dvs),
        .o_valid (d_valid),
        .o_tag   (d_tag),
        .o_y0    (d_y0),
        .o_quo   (d_quo)
    );

    // stage: signed quotient, zero when the start y is taken as it stands
    logic                      r5_valid;
    t_tag                      r5_tag;
    logic signed [CB-1:0]      r5_y0;
    logic signed [SUM_W-1:0]   r5_q;
    logic signed [SUM_W-1:0]   n5_qs;

    always_comb begin
        n5_qs = $signed(SUM_W'(d_quo));
        if (d_tag.bypass) begin
            n5_qs = '0;
        end else if (d_tag.qneg) begin
            n5_qs = -n5_qs;
        end
    end

    // stage: add the start y
    logic                      r6_valid;
    t_tag                      r6_tag;
    logic signed [SUM_W-1:0]   r6_sum;

    // stage: saturate into the result registers
    logic                      r_done;
    logic signed [VALUE_W-1:0] r_value;
    logic [SEG_W-1:0]          r_seg;
    logic                      r_zerr;
    logic                      r_ovf;
    logic                      n_ovf;
    logic signed [VALUE_W-1:0] n_value;

    always_comb begin
        // saturated when bit 31 and the bits above it do not all match the sign
        n_ovf = (r6_sum[SUM_W-1:VALUE_W-1] != '0) && (r6_sum[SUM_W-1:VALUE_W-1] != '1);
        if (!n_ovf) begin
            n_value = r6_sum[VALUE_W-1:0];
        end else if (r6_sum[SUM_W-1]) begin
            n_value = VALUE_MIN;
        end else begin
            n_value = VALUE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r5_valid <= d_valid;
            r6_valid <= r5_valid;
            r_done   <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_tag  <= d_tag;
        r5_y0   <= d_y0;
        r5_q    <= n5_qs;
        r6_tag  <= r5_tag;
        r6_sum  <= SUM_W'(r5_y0) + r5_q;
        r_value <= n_value;
        r_seg   <= r6_tag.seg;
        r_zerr  <= r6_tag.zerr;
        r_ovf   <= n_ovf;
    end

    assign o_done             = r_done;
    assign o_curve_value      = r_value;
    assign o_segment_index    = r_seg;
    assign o_zero_width_error = r_zerr;
    assign o_overflow_flag    = r_ovf;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted sample produced no result at the expected cycle");

    a_no_stray : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching sample");

    a_sat_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow_flag) |->
            (o_curve_value == VALUE_MAX || o_curve_value == VALUE_MIN))
        else $error("overflow flagged but value not at a limit");

    a_zerr_no_ovf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_width_error) |-> !o_overflow_flag)
        else $error("zero-width segment result saturated");

    a_seg_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_segment_index} + 4'd2 <= {1'b0, w_n_use}))
        else $error("segment index beyond the points in use");

endmodule

[tb/piecewise_linear_interpolator_core_tb.sv]
// self-checking bench for the piecewise-linear curve evaluator: directed table, then random curves
// depends on plc_pkg and piecewise_linear_interpolator_core; predicts result words in-bench, pinned rows apart
`timescale 1ns / 1ps

module piecewise_linear_interpolator_core_tb;
    import plc_pkg::*;

    localparam int N_POINTS       = MAX_POINTS_DEF;
    localparam int RESULT_LATENCY = 7 + (16 + COORD_BITS_DEF + 1) / 2;
    localparam int N_SCRIPT       = 50;
    localparam int BLOCK_ITEMS    = 48;
    localparam int SENDER_IDLE [3] = '{17, 83, 0};

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_POINT_BASE + CFG_IDX_W'(N_POINTS);
    localparam logic [CFG_IDX_W-1:0] REG_TOP          = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [SEG_W-1:0]          seg;
        logic                      zerr;
        logic                      ovf;
    } t_curve_result;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PROBE, ROW_PINNED} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] sample;
        t_curve_result              want;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [SAMPLE_W-1:0]   i_sample_in = '0;
    logic                         o_done;
    logic signed [VALUE_W-1:0]    o_curve_value;
    logic [SEG_W-1:0]             o_segment_index;
    logic                         o_zero_width_error;
    logic                         o_overflow_flag;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    // bench copy of the register file
    logic [PCOUNT_W-1:0]   cur_count;
    logic [CFG_DATA_W-1:0] cur_point [N_POINTS];

    t_curve_result awaited_values [$];
    t_curve_result oldest;
    t_row          script [N_SCRIPT];
    int            mismatch_count = 0;

    piecewise_linear_interpolator_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_sample_in        (i_sample_in),
        .o_done             (o_done),
        .o_curve_value      (o_curve_value),
        .o_segment_index    (o_segment_index),
        .o_zero_width_error (o_zero_width_error),
        .o_overflow_flag    (o_overflow_flag),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint coord_x(int k);
        return longint'(cur_point[k][PX_LSB +: 16]);
    endfunction

    function automatic longint coord_y(int k);
        return longint'(signed'(cur_point[k][15:0]));
    endfunction

    function automatic t_curve_result eval_curve(logic signed [SAMPLE_W-1:0] sample);
        t_curve_result r;
        int            n;
        int            k;
        longint        s;
        longint        x0;
        longint        dx;
        longint        y0;
        longint        v;
        r = '0;
        s = longint'(sample);
        n = int'(cur_count);
        if (n < MIN_POINTS) n = MIN_POINTS;
        if (n > N_POINTS) n = N_POINTS;
        k = 0;
        if (s < 0) begin
            v = coord_y(0);
        end else begin
            // last start at or below the sample, stopping at the first point beyond it
            while (k + 2 < n && s >= coord_x(k + 1)) k++;
            x0 = coord_x(k);
            y0 = coord_y(k);
            dx = coord_x(k + 1) - x0;
            if (dx == 0) begin
                v = y0;
                r.zerr = 1'b1;
            end else begin
                v = y0 + ((coord_y(k + 1) - y0) * (s - x0)) / dx;
            end
        end
        if (v > longint'(VALUE_MAX)) begin
            v = longint'(VALUE_MAX);
            r.ovf = 1'b1;
        end else if (v < longint'(VALUE_MIN)) begin
            v = longint'(VALUE_MIN);
            r.ovf = 1'b1;
        end
        r.value = v[VALUE_W-1:0];
        r.seg   = k[SEG_W-1:0];
        return r;
    endfunction

    function automatic t_row put_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row probe(int sample);
        t_row r;
        r = '0;
        r.kind   = ROW_PROBE;
        r.sample = SAMPLE_W'(sample);
        return r;
    endfunction

    function automatic t_row pinned(int sample, logic signed [VALUE_W-1:0] value,
                                    logic [SEG_W-1:0] seg, logic zerr, logic ovf);
        t_row r;
        r = '0;
        r.kind       = ROW_PINNED;
        r.sample     = SAMPLE_W'(sample);
        r.want.value = value;
        r.want.seg   = seg;
        r.want.zerr  = zerr;
        r.want.ovf   = ovf;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int p;
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'(-int'($urandom_range(1, 65536)));
            8: return SAMPLE_W'($urandom_range(0, 1023));
            9: return SAMPLE_W'($urandom_range(0, 65535));
            default: begin
                // land on or right beside a control point
                p = $urandom_range(0, N_POINTS - 1);
                return SAMPLE_W'(int'(cur_point[p][PX_LSB +: 16]) + int'($urandom_range(0, 6)) - 3);
            end
        endcase
    endfunction

    task automatic note_mismatch(string line);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", line);
    endtask

    // caller sits just after a rising edge; returns on the edge after the write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_POINT_COUNT) cur_count = data[PCOUNT_W-1:0];
        else if (idx < REG_FIRST_UNUSED) cur_point[idx - REG_POINT_BASE] = data;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] sample, logic is_pinned,
                               t_curve_result want, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_sample_in <= sample;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        awaited_values = {awaited_values, is_pinned ? want : eval_curve(sample)};
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (awaited_values.size() != 0) @(posedge i_clk);
    endtask

    task automatic shape_curve();
        int                    style;
        int                    step;
        int                    nx;
        logic [15:0]           y;
        logic [CFG_DATA_W-1:0] word;
        write_reg(REG_POINT_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
        style = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
            0: step = 4;
            1: step = 300;
            default: step = 9000;
        endcase
        nx = $urandom_range(0, 100);
        for (int k = 0; k < N_POINTS; k++) begin
            case (style)
                0: nx += $urandom_range(1, step);
                2: nx += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, step);
                3: nx += $urandom_range(1, 2);
                default: ;
            endcase
            if (nx > 65535) nx = 65535;
            // steep full-scale swings over narrow segments push the sum past 32 bits
            if (style == 3) y = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            else y = 16'($urandom);
            word = (style == 1) ? CFG_DATA_W'($urandom) : {16'(nx), y};
            write_reg(REG_POINT_BASE + CFG_IDX_W'(k), word);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_TOP)), $urandom);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (awaited_values.size() == 0) begin
                note_mismatch($sformatf("unexpected word: value %0d seg %0d zerr %0b ovf %0b",
                    o_curve_value, o_segment_index, o_zero_width_error, o_overflow_flag));
            end else begin
                oldest = awaited_values.pop_front();
                if (o_curve_value !== oldest.value || o_segment_index !== oldest.seg ||
                    o_zero_width_error !== oldest.zerr || o_overflow_flag !== oldest.ovf) begin
                    note_mismatch($sformatf(
                        "mismatch: want value %0d seg %0d zerr %0b ovf %0b, got %0d %0d %0b %0b",
                        oldest.value, oldest.seg, oldest.zerr, oldest.ovf, o_curve_value,
                        o_segment_index, o_zero_width_error, o_overflow_flag));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        cur_count = PCOUNT_RESET;
        foreach (cur_point[k]) cur_point[k] = '0;
        cur_point[1] = 32'h0001_0001;

        script = '{
            // reset curve: identity line through (0,0) and (1,1)
            pinned(0, 0, 0, 1'b0, 1'b0),
            pinned(1, 1, 0, 1'b0, 1'b0),
            pinned(65535, 65535, 0, 1'b0, 1'b0),
            pinned(-1, 0, 0, 1'b0, 1'b0),
            pinned(-65536, 0, 0, 1'b0, 1'b0),
            // writes past the last register are dropped
            put_cfg(REG_FIRST_UNUSED, 32'hffff_ffff),
            put_cfg(REG_TOP, 32'h8000_8000),
            pinned(40, 40, 0, 1'b0, 1'b0),
            // full-scale rise or fall over one step saturates high or low
            put_cfg(REG_POINT_BASE, {16'd0, 16'h8000}),
            put_cfg(REG_POINT_BASE + 4'd1, {16'd1, 16'h7fff}),
            pinned(65535, VALUE_MAX, 0, 1'b0, 1'b1),
            pinned(-65536, -32768, 0, 1'b0, 1'b0),
            put_cfg(REG_POINT_BASE, {16'd0, 16'h7fff}),
            put_cfg(REG_POINT_BASE + 4'd1, {16'd1, 16'h8000}),
            pinned(65535, VALUE_MIN, 0, 1'b0, 1'b1),
            // zero-width segment
            put_cfg(REG_POINT_BASE, {16'd5, 16'd100}),
            put_cfg(REG_POINT_BASE + 4'd1, {16'd5, 16'd200}),
            pinned(7, 100, 0, 1'b1, 1'b0),
            pinned(0, 100, 0, 1'b1, 1'b0),
            pinned(-3, 100, 0, 1'b0, 1'b0),
            // quotient truncates toward zero
            put_cfg(REG_POINT_BASE, {16'd0, 16'd0}),
            put_cfg(REG_POINT_BASE + 4'd1, {16'd3, 16'hffff}),
            pinned(1, 0, 0, 1'b0, 1'b0),
            pinned(5, -1, 0, 1'b0, 1'b0),
            // negative segment width
            put_cfg(REG_POINT_BASE, {16'd10, 16'd0}),
            put_cfg(REG_POINT_BASE + 4'd1, {16'd4, 16'd60}),
            probe(12),
            probe(3),
            // all seven points, extrapolating past the last
            put_cfg(REG_POINT_COUNT, 32'd7),
            put_cfg(REG_POINT_BASE, {16'd0, 16'hfc18}),
            put_cfg(REG_POINT_BASE + 4'd1, {16'd100, 16'd500}),
            put_cfg(REG_POINT_BASE + 4'd2, {16'd200, 16'd500}),
            put_cfg(REG_POINT_BASE + 4'd3, {16'd300, 16'h7fff}),
            put_cfg(REG_POINT_BASE + 4'd4, {16'd400, 16'h8000}),
            put_cfg(REG_POINT_BASE + 4'd5, {16'd500, 16'd0}),
            put_cfg(REG_POINT_BASE + 4'd6, {16'd600, 16'd7}),
            probe(0),
            probe(150),
            probe(300),
            probe(499),
            probe(600),
            probe(65535),
            // x going backwards
            put_cfg(REG_POINT_COUNT, 32'd4),
            put_cfg(REG_POINT_BASE + 4'd2, {16'd50, 16'd9}),
            probe(120),
            probe(70),
            // counts below the minimum act as two points
            put_cfg(REG_POINT_COUNT, 32'd0),
            probe(250),
            put_cfg(REG_POINT_COUNT, 32'd1),
            probe(65535)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_SCRIPT; i++) begin
            if (script[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_sample(script[i].sample, script[i].kind == ROW_PINNED, script[i].want,
                            SENDER_IDLE[0]);
            end
        end

        // fresh curve every block, registers only touched once the pipe is empty
        for (int p = 0; p < 3; p++) begin
            for (int b = 0; b < 8; b++) begin
                drain_results();
                shape_curve();
                for (int i = 0; i < BLOCK_ITEMS; i++)
                    send_sample(pick_sample(), 1'b0, '0, SENDER_IDLE[p]);
            end
        end

        drain_results();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_values.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
